// ----- hw/rtl/dbts_pkg.sv -----
// ----------------------------------------------------------------------------
// Depth block triangle select package
// Shared types, register indexes, triangle and edge tables.
// ----------------------------------------------------------------------------
package dbts_pkg;

    localparam int MAX_WIDTH  = 4096;
    localparam int MAX_HEIGHT = 4096;
    localparam int NUM_LANES  = 6;

    localparam logic [15:0] DISC_FACTOR_RESET = 16'd1280;

    typedef enum logic [2:0] {
        REG_DISC_FACTOR,
        REG_INV_00,
        REG_INV_01,
        REG_INV_02,
        REG_INV_10,
        REG_INV_11,
        REG_INV_12
    } reg_index_t;

    typedef enum logic [1:0] {
        TRI_021,
        TRI_031,
        TRI_023,
        TRI_123
    } tri_sel_t;

    localparam int EDGE_01 = 0;
    localparam int EDGE_02 = 1;
    localparam int EDGE_13 = 2;
    localparam int EDGE_23 = 3;
    localparam int EDGE_03 = 4;
    localparam int EDGE_12 = 5;

    typedef struct packed {
        logic [11:0] col;
        logic [11:0] row;
        logic [31:0] depth_0;
        logic [31:0] depth_1;
        logic [31:0] depth_2;
        logic [31:0] depth_3;
    } in_t;

    typedef struct packed {
        logic [11:0] out_col;
        logic [11:0] out_row;
        logic [1:0]  corner_a;
        logic [1:0]  corner_b;
        logic [1:0]  corner_c;
        logic        last;
    } out_t;

    typedef struct packed {
        logic [15:0] disc_factor;
        logic [31:0] inv_00;
        logic [31:0] inv_01;
        logic [31:0] inv_02;
        logic [31:0] inv_10;
        logic [31:0] inv_11;
        logic [31:0] inv_12;
    } cfg_t;

    typedef struct packed {
        logic        valid;
        logic [11:0] col;
        logic [11:0] row;
        logic [1:0]  nsel;
        tri_sel_t    sel0;
        tri_sel_t    sel1;
    } ctl_t;

    function automatic logic [1:0] edge_p(int e);
        logic [1:0] r;
        case (e)
            EDGE_01: r = 2'd0;
            EDGE_02: r = 2'd0;
            EDGE_13: r = 2'd1;
            EDGE_23: r = 2'd2;
            EDGE_03: r = 2'd0;
            default: r = 2'd1;
        endcase
        return r;
    endfunction

    function automatic logic [1:0] edge_q(int e);
        logic [1:0] r;
        case (e)
            EDGE_01: r = 2'd1;
            EDGE_02: r = 2'd2;
            EDGE_13: r = 2'd3;
            EDGE_23: r = 2'd3;
            EDGE_03: r = 2'd3;
            default: r = 2'd2;
        endcase
        return r;
    endfunction

    function automatic logic edge_diag(int e);
        return (e == EDGE_03) || (e == EDGE_12);
    endfunction

    // Mask over the edge lanes used by each triangle.
    function automatic logic [NUM_LANES-1:0] tri_edges(tri_sel_t s);
        logic [NUM_LANES-1:0] m;
        m = '0;
        case (s)
            TRI_021:
            begin
                m[EDGE_02] = 1'b1;
                m[EDGE_12] = 1'b1;
                m[EDGE_01] = 1'b1;
            end
            TRI_031:
            begin
                m[EDGE_03] = 1'b1;
                m[EDGE_13] = 1'b1;
                m[EDGE_01] = 1'b1;
            end
            TRI_023:
            begin
                m[EDGE_02] = 1'b1;
                m[EDGE_23] = 1'b1;
                m[EDGE_03] = 1'b1;
            end
            default:
            begin
                m[EDGE_12] = 1'b1;
                m[EDGE_23] = 1'b1;
                m[EDGE_13] = 1'b1;
            end
        endcase
        return m;
    endfunction

    function automatic out_t make_tri(logic [11:0] col, logic [11:0] row,
                                      tri_sel_t s, logic last);
        out_t o;
        o.out_col = col;
        o.out_row = row;
        o.last    = last;
        case (s)
            TRI_021:
            begin
                o.corner_a = 2'd0;
                o.corner_b = 2'd2;
                o.corner_c = 2'd1;
            end
            TRI_031:
            begin
                o.corner_a = 2'd0;
                o.corner_b = 2'd3;
                o.corner_c = 2'd1;
            end
            TRI_023:
            begin
                o.corner_a = 2'd0;
                o.corner_b = 2'd2;
                o.corner_c = 2'd3;
            end
            default:
            begin
                o.corner_a = 2'd1;
                o.corner_b = 2'd2;
                o.corner_c = 2'd3;
            end
        endcase
        return o;
    endfunction

endpackage

// ----- hw/rtl/dbts_lane.sv -----
// ----------------------------------------------------------------------------
// Depth block triangle select edge lane
// Eight-stage pipelined depth discontinuity test of one block edge.
// ----------------------------------------------------------------------------
module dbts_lane (
    input  logic              clk,
    input  logic              en,
    input  logic [31:0]       dp,
    input  logic [31:0]       dq,
    input  logic [11:0]       col,
    input  logic [11:0]       row,
    input  logic [1:0]        p_corner,
    input  logic [1:0]        q_corner,
    input  logic              diag,
    input  dbts_pkg::cfg_t    cfg,
    output logic              brk
);

    localparam logic [93:0] N2_BIAS = 94'd1 << 58;

    logic        swap;
    logic [1:0]  m_corner;

    logic [31:0] s0_dm_reg, s0_diff_reg;
    logic [12:0] s0_mx_reg, s0_my_reg;
    logic        s0_nz_reg;

    logic signed [46:0] s1_px0_reg, s1_px1_reg, s1_py0_reg, s1_py1_reg;
    logic [62:0] s1_t_reg;
    logic [63:0] s1_dd_reg;
    logic        s1_nz_reg;

    logic [47:0] s2_vx_reg, s2_vy_reg;
    logic [78:0] s2_tf_reg;
    logic [63:0] s2_dd_reg;
    logic        s2_nz_reg;

    logic [47:0] ux48, uy48;
    logic [45:0] ux, uy;
    logic [45:0] s3_xhh_reg, s3_xhl_reg, s3_xll_reg;
    logic [45:0] s3_yhh_reg, s3_yhl_reg, s3_yll_reg;
    logic [53:0] s3_c00_reg, s3_c01_reg, s3_c11_reg;
    logic [51:0] s3_c02_reg, s3_c12_reg;
    logic [49:0] s3_c22_reg;
    logic [63:0] s3_dd_reg;
    logic        s3_nz_reg;

    logic [91:0]  ux2, uy2;
    logic [157:0] tf2;
    logic [93:0]  s4_n2_reg;
    logic [158:0] s4_rhs_reg;
    logic [63:0]  s4_dd_reg;
    logic         s4_nz_reg;

    logic [63:0]  s5_a0b0_reg, s5_a0b1_reg, s5_a1b0_reg, s5_a1b1_reg;
    logic [61:0]  s5_a0b2_reg, s5_a1b2_reg;
    logic [158:0] s5_rhs_reg;
    logic         s5_nz_reg;

    logic [157:0] s6_lhs_reg;
    logic [158:0] s6_rhs_reg;
    logic         s6_nz_reg;

    logic         brk_reg;

    assign swap     = dq < dp;
    assign m_corner = swap ? q_corner : p_corner;

    assign ux48 = s2_vx_reg[47] ? (48'd0 - s2_vx_reg) : s2_vx_reg;
    assign uy48 = s2_vy_reg[47] ? (48'd0 - s2_vy_reg) : s2_vy_reg;
    assign ux   = ux48[45:0];
    assign uy   = uy48[45:0];

    assign ux2 = {s3_xhh_reg, 46'd0} + {22'd0, s3_xhl_reg, 24'd0} + {46'd0, s3_xll_reg};
    assign uy2 = {s3_yhh_reg, 46'd0} + {22'd0, s3_yhl_reg, 24'd0} + {46'd0, s3_yll_reg};
    assign tf2 = {104'd0, s3_c00_reg} + {76'd0, s3_c01_reg, 28'd0}
               + {50'd0, s3_c11_reg, 54'd0} + {51'd0, s3_c02_reg, 55'd0}
               + {24'd0, s3_c12_reg, 82'd0} + {s3_c22_reg, 108'd0};

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s0_dm_reg   <= swap ? dq : dp;
            s0_diff_reg <= swap ? (dp - dq) : (dq - dp);
            s0_nz_reg   <= dp != dq;
            s0_mx_reg   <= {1'b0, col} + {12'd0, m_corner[0]};
            s0_my_reg   <= {1'b0, row} + {12'd0, m_corner[1]};

            s1_px0_reg <= $signed(cfg.inv_00) * $signed({2'b00, s0_mx_reg, 1'b1});
            s1_px1_reg <= $signed(cfg.inv_01) * $signed({2'b00, s0_my_reg, 1'b1});
            s1_py0_reg <= $signed(cfg.inv_10) * $signed({2'b00, s0_mx_reg, 1'b1});
            s1_py1_reg <= $signed(cfg.inv_11) * $signed({2'b00, s0_my_reg, 1'b1});
            s1_t_reg   <= cfg.inv_00[30:0] * s0_dm_reg;
            s1_dd_reg  <= s0_diff_reg * s0_diff_reg;
            s1_nz_reg  <= s0_nz_reg;

            s2_vx_reg <= {s1_px0_reg[46], s1_px0_reg} + {s1_px1_reg[46], s1_px1_reg}
                       + {{15{cfg.inv_02[31]}}, cfg.inv_02, 1'b0};
            s2_vy_reg <= {s1_py0_reg[46], s1_py0_reg} + {s1_py1_reg[46], s1_py1_reg}
                       + {{15{cfg.inv_12[31]}}, cfg.inv_12, 1'b0};
            s2_tf_reg <= s1_t_reg * cfg.disc_factor;
            s2_dd_reg <= s1_dd_reg;
            s2_nz_reg <= s1_nz_reg;

            s3_xhh_reg <= ux[45:23] * ux[45:23];
            s3_xhl_reg <= ux[45:23] * ux[22:0];
            s3_xll_reg <= ux[22:0] * ux[22:0];
            s3_yhh_reg <= uy[45:23] * uy[45:23];
            s3_yhl_reg <= uy[45:23] * uy[22:0];
            s3_yll_reg <= uy[22:0] * uy[22:0];
            s3_c00_reg <= s2_tf_reg[26:0] * s2_tf_reg[26:0];
            s3_c01_reg <= s2_tf_reg[26:0] * s2_tf_reg[53:27];
            s3_c11_reg <= s2_tf_reg[53:27] * s2_tf_reg[53:27];
            s3_c02_reg <= s2_tf_reg[26:0] * s2_tf_reg[78:54];
            s3_c12_reg <= s2_tf_reg[53:27] * s2_tf_reg[78:54];
            s3_c22_reg <= s2_tf_reg[78:54] * s2_tf_reg[78:54];
            s3_dd_reg  <= s2_dd_reg;
            s3_nz_reg  <= s2_nz_reg;

            s4_n2_reg  <= {2'd0, ux2} + {2'd0, uy2} + N2_BIAS;
            s4_rhs_reg <= diag ? {tf2, 1'b0} : {1'b0, tf2};
            s4_dd_reg  <= s3_dd_reg;
            s4_nz_reg  <= s3_nz_reg;

            s5_a0b0_reg <= s4_dd_reg[31:0] * s4_n2_reg[31:0];
            s5_a0b1_reg <= s4_dd_reg[31:0] * s4_n2_reg[63:32];
            s5_a1b0_reg <= s4_dd_reg[63:32] * s4_n2_reg[31:0];
            s5_a1b1_reg <= s4_dd_reg[63:32] * s4_n2_reg[63:32];
            s5_a0b2_reg <= s4_dd_reg[31:0] * s4_n2_reg[93:64];
            s5_a1b2_reg <= s4_dd_reg[63:32] * s4_n2_reg[93:64];
            s5_rhs_reg  <= s4_rhs_reg;
            s5_nz_reg   <= s4_nz_reg;

            s6_lhs_reg <= {94'd0, s5_a0b0_reg} + {62'd0, s5_a0b1_reg, 32'd0}
                        + {62'd0, s5_a1b0_reg, 32'd0} + {32'd0, s5_a0b2_reg, 64'd0}
                        + {30'd0, s5_a1b1_reg, 64'd0} + {s5_a1b2_reg, 96'd0};
            s6_rhs_reg <= s5_rhs_reg;
            s6_nz_reg  <= s5_nz_reg;

            if (cfg.inv_00[31])
            begin
                brk_reg <= 1'b1;
            end
            else if (cfg.inv_00 == 32'd0)
            begin
                brk_reg <= s6_nz_reg;
            end
            else
            begin
                brk_reg <= {s6_lhs_reg, 14'd0} > {13'd0, s6_rhs_reg};
            end
        end
    end

    assign brk = brk_reg;

endmodule

// ----- hw/rtl/dbts_merge.sv -----
// ----------------------------------------------------------------------------
// Depth block triangle select merge stage
// Combines the lane results into kept triangles and buffers them for output.
// ----------------------------------------------------------------------------
module dbts_merge (
    input  logic                              clk,
    input  logic                              rst_n,
    input  dbts_pkg::ctl_t                    ctl,
    input  logic [dbts_pkg::NUM_LANES-1:0]    brk,
    input  logic [15:0]                       disc_factor,
    output logic                              can_take,
    output logic                              trg_valid,
    input  logic                              trg_stall,
    output dbts_pkg::out_t                    trg
);

    logic [1:0]     cnt_reg, cnt_next;
    dbts_pkg::out_t ent0_reg, ent1_reg;
    dbts_pkg::out_t e0, e1;
    logic [1:0]     n;
    logic           drop0, drop1, k0, k1, take, load;

    assign take     = (cnt_reg != 2'd0) && !trg_stall;
    assign can_take = (cnt_reg == 2'd0) || ((cnt_reg == 2'd1) && take);
    assign load     = ctl.valid && can_take;

    always_comb
    begin
        drop0 = (disc_factor != 16'd0) && (|(brk & dbts_pkg::tri_edges(ctl.sel0)));
        drop1 = (disc_factor != 16'd0) && (|(brk & dbts_pkg::tri_edges(ctl.sel1)));
        k0    = (ctl.nsel != 2'd0) && !drop0;
        k1    = (ctl.nsel == 2'd2) && !drop1;
        e0    = dbts_pkg::make_tri(ctl.col, ctl.row, ctl.sel1, 1'b1);
        e1    = e0;
        n     = 2'd0;
        if (k0)
        begin
            e0 = dbts_pkg::make_tri(ctl.col, ctl.row, ctl.sel0, !k1);
            n  = k1 ? 2'd2 : 2'd1;
        end
        else if (k1)
        begin
            n = 2'd1;
        end

        cnt_next = cnt_reg;
        if (load)
        begin
            cnt_next = n;
        end
        else if (take)
        begin
            cnt_next = cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= 2'd0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            ent0_reg <= e0;
            ent1_reg <= e1;
        end
        else if (take)
        begin
            ent0_reg <= ent1_reg;
        end
    end

    assign trg_valid = cnt_reg != 2'd0;
    assign trg       = ent0_reg;

endmodule

// ----- hw/rtl/depth_block_triangle_select.sv -----
// An accepted block passes the c0 registers and the control pipeline in step with
// the edge lanes, and its triangles are registered in the merge buffer. Throughput:
// one block per cycle while blk_stall is low; a block with two triangles holds the
// output port for both. Pipeline depth is set by the eight-stage wide multiply chain in
// each edge lane. Reset clears all valid state and loads the configuration reset values.
// ----------------------------------------------------------------------------
// Depth block triangle select
// Triangulates a 2x2 depth block with six parallel edge discontinuity lanes.
// ----------------------------------------------------------------------------
module depth_block_triangle_select (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            cfg_wen,
    input  logic [2:0]      cfg_addr,
    input  logic [31:0]     cfg_data,
    input  logic            blk_valid,
    output logic            blk_stall,
    input  dbts_pkg::in_t   blk,
    output logic            trg_valid,
    input  logic            trg_stall,
    output dbts_pkg::out_t  trg
);

    localparam int CTL_DEPTH = 7;

    dbts_pkg::cfg_t cfg_reg;
    logic           adv, can_take;
    logic [31:0]    dep [4];
    logic [dbts_pkg::NUM_LANES-1:0] brk;

    logic           c0_valid_reg;
    logic [11:0]    c0_col_reg, c0_row_reg;
    logic [3:0]     c0_mask_reg;
    logic           c0_inr_reg;
    logic [31:0]    c0_ad_reg, c0_bd_reg;
    dbts_pkg::ctl_t ctl_next;
    dbts_pkg::ctl_t ctl_pipe_reg [CTL_DEPTH];
    logic [CTL_DEPTH-1:0] ctl_vld_reg;
    dbts_pkg::ctl_t ctl_out;

    assign dep[0] = blk.depth_0;
    assign dep[1] = blk.depth_1;
    assign dep[2] = blk.depth_2;
    assign dep[3] = blk.depth_3;

    assign adv       = !ctl_vld_reg[CTL_DEPTH-1] || can_take;
    assign blk_stall = !adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.disc_factor <= dbts_pkg::DISC_FACTOR_RESET;
            cfg_reg.inv_00      <= 32'd0;
            cfg_reg.inv_01      <= 32'd0;
            cfg_reg.inv_02      <= 32'd0;
            cfg_reg.inv_10      <= 32'd0;
            cfg_reg.inv_11      <= 32'd0;
            cfg_reg.inv_12      <= 32'd0;
        end
        else if (cfg_wen)
        begin
            unique case (cfg_addr)
                dbts_pkg::REG_DISC_FACTOR: cfg_reg.disc_factor <= cfg_data[15:0];
                dbts_pkg::REG_INV_00:      cfg_reg.inv_00      <= cfg_data;
                dbts_pkg::REG_INV_01:      cfg_reg.inv_01      <= cfg_data;
                dbts_pkg::REG_INV_02:      cfg_reg.inv_02      <= cfg_data;
                dbts_pkg::REG_INV_10:      cfg_reg.inv_10      <= cfg_data;
                dbts_pkg::REG_INV_11:      cfg_reg.inv_11      <= cfg_data;
                dbts_pkg::REG_INV_12:      cfg_reg.inv_12      <= cfg_data;
                default:                   cfg_reg             <= cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        ctl_next.valid = c0_valid_reg;
        ctl_next.col   = c0_col_reg;
        ctl_next.row   = c0_row_reg;
        ctl_next.nsel  = 2'd0;
        ctl_next.sel0  = dbts_pkg::TRI_021;
        ctl_next.sel1  = dbts_pkg::TRI_123;
        unique case (c0_mask_reg)
            4'd7:
            begin
                ctl_next.nsel = 2'd1;
                ctl_next.sel0 = dbts_pkg::TRI_021;
            end
            4'd11:
            begin
                ctl_next.nsel = 2'd1;
                ctl_next.sel0 = dbts_pkg::TRI_031;
            end
            4'd13:
            begin
                ctl_next.nsel = 2'd1;
                ctl_next.sel0 = dbts_pkg::TRI_023;
            end
            4'd14:
            begin
                ctl_next.nsel = 2'd1;
                ctl_next.sel0 = dbts_pkg::TRI_123;
            end
            4'd15:
            begin
                ctl_next.nsel = 2'd2;
                if (c0_ad_reg < c0_bd_reg)
                begin
                    ctl_next.sel0 = dbts_pkg::TRI_031;
                    ctl_next.sel1 = dbts_pkg::TRI_023;
                end
            end
            default:
            begin
                ctl_next.nsel = 2'd0;
            end
        endcase
        if (!c0_inr_reg)
        begin
            ctl_next.nsel = 2'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            c0_valid_reg <= 1'b0;
            ctl_vld_reg  <= '0;
        end
        else if (adv)
        begin
            c0_valid_reg <= blk_valid;
            ctl_vld_reg  <= {ctl_vld_reg[CTL_DEPTH-2:0], c0_valid_reg};
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            c0_col_reg  <= blk.col;
            c0_row_reg  <= blk.row;
            c0_mask_reg <= {dep[3] != 32'd0, dep[2] != 32'd0,
                            dep[1] != 32'd0, dep[0] != 32'd0};
            c0_inr_reg  <= ((32'(blk.col) + 32'd2) <= 32'(dbts_pkg::MAX_WIDTH))
                        && ((32'(blk.row) + 32'd2) <= 32'(dbts_pkg::MAX_HEIGHT));
            c0_ad_reg   <= (dep[0] > dep[3]) ? (dep[0] - dep[3]) : (dep[3] - dep[0]);
            c0_bd_reg   <= (dep[1] > dep[2]) ? (dep[1] - dep[2]) : (dep[2] - dep[1]);
            ctl_pipe_reg[0] <= ctl_next;
            for (int i = 1; i < CTL_DEPTH; i++)
            begin
                ctl_pipe_reg[i] <= ctl_pipe_reg[i-1];
            end
        end
    end

    always_comb
    begin
        ctl_out       = ctl_pipe_reg[CTL_DEPTH-1];
        ctl_out.valid = ctl_vld_reg[CTL_DEPTH-1];
    end

    for (genvar e = 0; e < dbts_pkg::NUM_LANES; e++)
    begin : g_lane
        dbts_lane u_lane (
            .clk      (clk),
            .en       (adv),
            .dp       (dep[dbts_pkg::edge_p(e)]),
            .dq       (dep[dbts_pkg::edge_q(e)]),
            .col      (blk.col),
            .row      (blk.row),
            .p_corner (dbts_pkg::edge_p(e)),
            .q_corner (dbts_pkg::edge_q(e)),
            .diag     (dbts_pkg::edge_diag(e)),
            .cfg      (cfg_reg),
            .brk      (brk[e])
        );
    end

    dbts_merge u_merge (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctl         (ctl_out),
        .brk         (brk),
        .disc_factor (cfg_reg.disc_factor),
        .can_take    (can_take),
        .trg_valid   (trg_valid),
        .trg_stall   (trg_stall),
        .trg         (trg)
    );

endmodule

// ----- hw/rtl/dbts_checker.sv -----
// ----------------------------------------------------------------------------
// Depth block triangle select checker
// Port-level properties of the triangle output and the input stall.
// ----------------------------------------------------------------------------
module dbts_props (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            blk_stall,
    input  logic            trg_valid,
    input  logic            trg_stall,
    input  dbts_pkg::out_t  trg
);

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        trg_valid && trg_stall |=> trg_valid && $stable(trg))
        else $error("Stalled triangle transaction changed.");

    a_pair: assert property (@(posedge clk) disable iff (!rst_n)
        trg_valid && !trg_stall && !trg.last |=> trg_valid)
        else $error("Second triangle of a block did not follow at once.");

    a_corner: assert property (@(posedge clk) disable iff (!rst_n)
        trg_valid |-> trg.corner_b[1] && (trg.corner_a == 2'd0 || trg.corner_a == 2'd1))
        else $error("Triangle corners are not from the triangle table.");

    a_stall: assert property (@(posedge clk) disable iff (!rst_n)
        blk_stall |-> trg_valid)
        else $error("Input stalled while no triangle transaction was pending.");

endmodule

bind depth_block_triangle_select dbts_props u_dbts_props (
    .clk       (clk),
    .rst_n     (rst_n),
    .blk_stall (blk_stall),
    .trg_valid (trg_valid),
    .trg_stall (trg_stall),
    .trg       (trg)
);
